/* rtl/core/lfo_pkg.sv */
// ----------------------------------------------------------------------------
// lfo_pkg
// Types, register indexes and sine table generation for the LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned SAMPLE_BITS    = 16;
    localparam int unsigned ROM_DATA_BITS  = 15;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SHAPE = 2'd1;

    typedef enum logic [1:0] {
        SHAPE_SAW  = 2'd0,
        SHAPE_TRI  = 2'd1,
        SHAPE_SINE = 2'd2,
        SHAPE_ZERO = 2'd3
    } t_shape;

    // Q30 magnitudes of the odd-power coefficients of sin(pi/2 x)
    localparam logic [63:0] K1  = 64'd1686629713;
    localparam logic [63:0] K3  = 64'd693598668;
    localparam logic [63:0] K5  = 64'd85569306;
    localparam logic [63:0] K7  = 64'd5026995;
    localparam logic [63:0] K9  = 64'd172272;
    localparam logic [63:0] K11 = 64'd3864;

    // quarter-wave entry at the midpoint of slot idx, Q0.15 magnitude
    function automatic logic [ROM_DATA_BITS-1:0] rom_entry(input int unsigned idx,
                                                           input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = 64'(2 * idx + 1) << (29 - tbits);
        x2 = (x * x) >> 30;
        t  = K11;
        t  = K9 - ((x2 * t) >> 30);
        t  = K7 - ((x2 * t) >> 30);
        t  = K5 - ((x2 * t) >> 30);
        t  = K3 - ((x2 * t) >> 30);
        t  = K1 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[ROM_DATA_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lfo_sine_rom.sv */
// ----------------------------------------------------------------------------
// lfo_sine_rom
// Quarter-wave sine table, one registered read per cycle with enable.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_sine_rom #(
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [TABLE_BITS-1:0]             i_addr,
    output logic      [lfo_pkg::ROM_DATA_BITS-1:0] o_data
);
    import lfo_pkg::*;

    localparam int unsigned ROM_SIZE = 1 << TABLE_BITS;

    typedef logic [ROM_DATA_BITS-1:0] t_rom [ROM_SIZE];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int unsigned i = 0; i < ROM_SIZE; i++) begin
            rom[i] = rom_entry(i, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [ROM_DATA_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* rtl/core/lfo_phase_accumulator_waveform.sv */
// ----------------------------------------------------------------------------
// lfo_phase_accumulator_waveform
// Phase-accumulator LFO: saw, triangle, table sine or zero sample per request.
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_ready | i_clear_phase
//   out     | output    | o_out_valid/i_out_ready | o_sample_out
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while out is not stalled; a request passes stage
// one, which holds the phase snapshot and the registered sine table read,
// then stage two, the output register. A stall on out holds both stages;
// in is ready while stage one is free or advances. Reset clears the phase,
// the cfg registers and all valid flags, not stage data. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_phase_accumulator_waveform #(
    parameter int unsigned PHASE_BITS = 32,
    parameter int unsigned TABLE_BITS = 10
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_clear_phase,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [lfo_pkg::SAMPLE_BITS-1:0]  o_sample_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lfo_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [lfo_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import lfo_pkg::*;

    logic signed [CFG_DATA_BITS-1:0] r_phase_step;
    t_shape                          r_wave_shape;
    logic [PHASE_BITS-1:0]           r_phase;

    logic                            r_s1_valid;
    t_shape                          r_s1_shape;
    logic [SAMPLE_BITS-1:0]          r_s1_high;
    logic                            r_s1_neg;

    logic                            r_out_valid;
    logic [SAMPLE_BITS-1:0]          r_sample;

    logic                            w_acc;
    logic                            w_adv;
    logic                            w_cfg_acc;
    logic [PHASE_BITS-1:0]           w_step_ext;
    logic [PHASE_BITS-1:0]           w_phase_cur;
    logic [1:0]                      w_quad;
    logic [TABLE_BITS-1:0]           w_idx;
    logic [TABLE_BITS-1:0]           w_addr;
    logic [ROM_DATA_BITS-1:0]        w_rom_data;
    logic signed [16:0]              w_bias;
    logic [16:0]                     w_mag;
    logic signed [17:0]              w_tri;
    logic [SAMPLE_BITS-1:0]          n_sample;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_wave_shape <= SHAPE_SAW;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                REG_PHASE_STEP: r_phase_step <= $signed(i_cfg_data);
                REG_WAVE_SHAPE: r_wave_shape <= t_shape'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_step_ext  = PHASE_BITS'(r_phase_step);
    assign w_phase_cur = i_clear_phase ? '0 : r_phase;
    assign w_quad      = w_phase_cur[PHASE_BITS-1 -: 2];
    assign w_idx       = w_phase_cur[PHASE_BITS-3 -: TABLE_BITS];
    assign w_addr      = w_quad[0] ? ~w_idx : w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_acc) begin
            r_phase <= w_phase_cur + w_step_ext;
        end
    end

    lfo_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (o_in_ready),
        .i_addr (w_addr),
        .o_data (w_rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_shape <= r_wave_shape;
            r_s1_high  <= w_phase_cur[PHASE_BITS-1 -: SAMPLE_BITS];
            r_s1_neg   <= w_quad[1];
        end
    end

    assign w_bias = $signed({1'b0, r_s1_high}) - 17'sd32768;
    assign w_mag  = w_bias[16] ? 17'(-w_bias) : w_bias;
    assign w_tri  = $signed({w_mag, 1'b0}) - 18'sd32768;

    always_comb begin
        case (r_s1_shape)
            SHAPE_SAW:  n_sample = {~r_s1_high[15], r_s1_high[14:0]};
            SHAPE_TRI:  n_sample = (w_tri > 18'sd32767) ? 16'h7FFF : w_tri[15:0];
            SHAPE_SINE: n_sample = r_s1_neg ? 16'(16'd0 - {1'b0, w_rom_data})
                                            : {1'b0, w_rom_data};
            default:    n_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sample <= n_sample;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = $signed(r_sample);

    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_s1_valid)
        else $error("accepted request did not reach stage one");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid)
        else $error("stage one dropped a request under stall");

    a_phase_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_clear_phase) |=> r_phase == $past(r_phase + w_step_ext))
        else $error("phase did not advance by the step");

    a_phase_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_clear_phase) |=> r_phase == $past(w_step_ext))
        else $error("cleared phase did not restart from zero");

    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_phase))
        else $error("phase moved without a request");

endmodule

`default_nettype wire
